### design/crc16rr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crc16rr_pkg
// Shared types, constants and the byte-wide CRC-16 update of the request and
// reply framer.
// ---------------------------------------------------------------------------
package crc16rr_pkg;

	localparam int WRITE_MAX_DEFAULT = 64;
	localparam int REPLY_MAX_DEFAULT = 256;

	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [7:0]  EXC_FLAG       = 8'h80;
	localparam logic [7:0]  DEV_ADDR_RESET = 8'd1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_END     = 2'd2,
		KIND_REPLY   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OUT_TX      = 2'd0,
		OUT_PAYLOAD = 2'd1,
		OUT_STATUS  = 2'd2
	} okind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_PARAM     = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_FORMAT    = 3'd4,
		ST_CRC       = 3'd5,
		ST_EXCEPTION = 3'd6
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  func_code;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		okind_t      out_kind;
		logic [7:0]  out_byte;
		status_t     status;
		logic [7:0]  exception_code;
		logic [7:0]  payload_length;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]  count;
		result_t     first;
		result_t     second;
	} push_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### design/crc16_request_reply_framer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crc16_request_reply_framer
// Builds CRC-16 protected request frames and checks length-prefixed reply
// frames, forwarding reply payload bytes and a final status.
// ---------------------------------------------------------------------------
//  Channel   Direction  Signals                          Contents
//  s_*       in         s_tvalid s_tready s_tdata s_tuser item kind and bytes
//  m_*       out        m_tvalid m_tready m_tdata m_tuser m_tlast results
//  cfg_*     in         cfg_valid cfg_ready cfg_data     device address
//
// One item is taken every cycle while the result queue has room; start and end
// request items each produce two results. An item is held in the input register
// while the byte-wide CRC update forms its results, which are then written into
// the four-entry result queue and offered from there. Reset clears all control
// state and sets the device address to 1. The input stalls only when the result
// queue lacks room for two more results.
// ---------------------------------------------------------------------------
module crc16_request_reply_framer #(
	parameter int WRITE_MAX = crc16rr_pkg::WRITE_MAX_DEFAULT,
	parameter int REPLY_MAX = crc16rr_pkg::REPLY_MAX_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // func_code [7:0], data_byte [15:8]
	input  logic [1:0]   s_tuser,   // kind [1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // out_byte [7:0], status [10:8],
	                                // exception_code [18:11], payload_length [26:19]
	output logic [1:0]   m_tuser,   // out_kind [1:0]
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data
);
	import crc16rr_pkg::*;

	item_t    item_s1;
	logic     valid_s1;
	logic     fire;
	logic     room;
	push_t    push;
	result_t  head;

	assign fire      = valid_s1 && room;
	assign s_tready  = !valid_s1 || fire;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind      <= kind_t'(s_tuser);
			item_s1.func_code <= s_tdata[7:0];
			item_s1.data_byte <= s_tdata[15:8];
		end
	end

	crc16rr_engine #(
		.WRITE_MAX (WRITE_MAX),
		.REPLY_MAX (REPLY_MAX)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.push      (push)
	);

	crc16rr_result_fifo u_result_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.head    (head)
	);

	assign m_tdata = {5'b00000, head.payload_length, head.exception_code, head.status,
		head.out_byte};
	assign m_tuser = head.out_kind;
	assign m_tlast = head.last;

endmodule
`default_nettype wire

### design/crc16rr_engine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crc16rr_engine
// Framing state, CRC unit and result formation for one registered item per
// cycle, taken only while the result queue has room (fire).
// ---------------------------------------------------------------------------
module crc16rr_engine #(
	parameter int WRITE_MAX = crc16rr_pkg::WRITE_MAX_DEFAULT,
	parameter int REPLY_MAX = crc16rr_pkg::REPLY_MAX_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  crc16rr_pkg::item_t   item,
	input  logic                 cfg_valid,
	input  logic [7:0]           cfg_data,
	output crc16rr_pkg::push_t   push
);
	import crc16rr_pkg::*;

	localparam int CNT_W = (WRITE_MAX < 1) ? 1 : $clog2(WRITE_MAX + 1);

	typedef enum logic [2:0] {
		PH_IDLE, PH_BUILD, PH_LENLO, PH_LENHI, PH_BODY, PH_TAIL1, PH_TAIL2, PH_DRAIN
	} phase_t;

	phase_t             phase_q, n_phase;
	logic [7:0]         dev_addr_q;
	logic [15:0]        dev_crc_q;
	logic [15:0]        crc_q, n_crc;
	logic [7:0]         exp_q, n_exp;
	logic [CNT_W-1:0]   cnt_q, n_cnt;
	logic [15:0]        prefix_q, n_prefix;
	logic [15:0]        pos_q, n_pos;
	logic               rep_q, n_rep;
	logic [7:0]         reply_q, n_reply;
	logic [7:0]         h0_q, h1_q, h2_q, n_h0, n_h1, n_h2;
	logic [15:0]        sp1_q, sp2_q, n_sp1, n_sp2;

	logic               in_body;
	logic [16:0]        idx;
	logic [16:0]        len17;
	logic               rep_now, rep_eff;
	logic [16:0]        f_idx;
	logic [17:0]        f_plus3;
	logic [16:0]        pos_inc;
	logic [15:0]        pref_full;
	logic [15:0]        crc_base;
	logic [7:0]         crc_in;
	logic [15:0]        crc_out;
	push_t              push_c;

	function automatic result_t mk_res(okind_t k, logic [7:0] ob, status_t st,
			logic [7:0] ex, logic [7:0] pl, logic lst);
		result_t r;
		r.out_kind       = k;
		r.out_byte       = ob;
		r.status         = st;
		r.exception_code = ex;
		r.payload_length = pl;
		r.last           = lst;
		return r;
	endfunction

	function automatic result_t final_res(logic [15:0] len, logic [15:0] crc,
			logic [7:0] h0, logic [7:0] rc, logic [7:0] h2, logic [7:0] dev,
			logic [7:0] ef);
		logic [15:0] lm4;
		status_t     st;
		logic [7:0]  ex;
		logic [7:0]  pl;
		lm4 = len - 16'd4;
		ex  = 8'h00;
		pl  = 8'h00;
		if (len < 16'd4) begin
			st = ST_FORMAT;
		end else if (crc != 16'h0000) begin
			st = ST_CRC;
		end else if (h0 != dev) begin
			st = ST_FORMAT;
		end else if (rc == (ef | EXC_FLAG)) begin
			st = ST_EXCEPTION;
			ex = (len >= 16'd5) ? h2 : 8'h00;
		end else if (rc != ef) begin
			st = ST_FORMAT;
		end else begin
			st = ST_OK;
			pl = (lm4[15:8] != 8'h00) ? 8'hFF : lm4[7:0];
		end
		return mk_res(OUT_STATUS, 8'h00, st, ex, pl, 1'b1);
	endfunction

	assign in_body = (item.kind == KIND_REPLY) &&
		((phase_q == PH_BODY) || (phase_q == PH_TAIL1) || (phase_q == PH_TAIL2));

	assign len17 = {1'b0, prefix_q};

	always_comb begin
		case (phase_q)
			PH_BODY:  idx = {1'b0, pos_q};
			PH_TAIL1: idx = len17;
			PH_TAIL2: idx = len17 + 17'd1;
			default:  idx = 17'd0;
		endcase
	end

	assign rep_now = (h0_q == prefix_q[7:0]) && (h1_q == prefix_q[15:8]) &&
		(item.data_byte == dev_addr_q);
	assign rep_eff = (idx == 17'd2) ? rep_now : rep_q;
	assign f_idx   = rep_eff ? (idx - 17'd2) : idx;
	assign f_plus3 = {1'b0, f_idx} + 18'd3;
	assign pos_inc = {1'b0, pos_q} + 17'd1;
	assign pref_full = {item.data_byte, prefix_q[7:0]};

	assign crc_base = (item.kind == KIND_START) ? dev_crc_q :
		(in_body && (idx == 17'd1)) ? sp1_q :
		(in_body && (idx == 17'd2) && !rep_now) ? sp2_q : crc_q;
	assign crc_in  = (item.kind == KIND_START) ? item.func_code : item.data_byte;
	assign crc_out = crc_byte(crc_base, crc_in);

	always_comb begin
		n_phase  = phase_q;
		n_crc    = crc_q;
		n_exp    = exp_q;
		n_cnt    = cnt_q;
		n_prefix = prefix_q;
		n_pos    = pos_q;
		n_rep    = rep_q;
		n_reply  = reply_q;
		n_h0     = h0_q;
		n_h1     = h1_q;
		n_h2     = h2_q;
		n_sp1    = sp1_q;
		n_sp2    = sp2_q;
		push_c   = '0;
		if (fire) begin
			case (item.kind)
				KIND_START: begin
					n_exp   = item.func_code;
					n_cnt   = '0;
					n_crc   = crc_out;
					n_phase = PH_BUILD;
					push_c.count  = 2'd2;
					push_c.first  = mk_res(OUT_TX, dev_addr_q, ST_OK, 8'h00, 8'h00, 1'b0);
					push_c.second = mk_res(OUT_TX, item.func_code, ST_OK, 8'h00, 8'h00,
						1'b0);
				end
				KIND_PAYLOAD: begin
					if (phase_q == PH_BUILD) begin
						if (cnt_q >= CNT_W'(WRITE_MAX)) begin
							n_phase = PH_IDLE;
							push_c.count = 2'd1;
							push_c.first = mk_res(OUT_STATUS, 8'h00, ST_PARAM, 8'h00, 8'h00,
								1'b1);
						end else begin
							n_cnt = cnt_q + CNT_W'(1);
							n_crc = crc_out;
							push_c.count = 2'd1;
							push_c.first = mk_res(OUT_TX, item.data_byte, ST_OK, 8'h00, 8'h00,
								1'b0);
						end
					end
				end
				KIND_END: begin
					if (phase_q == PH_BUILD) begin
						n_phase = PH_LENLO;
						push_c.count  = 2'd2;
						push_c.first  = mk_res(OUT_TX, crc_q[7:0], ST_OK, 8'h00, 8'h00, 1'b0);
						push_c.second = mk_res(OUT_TX, crc_q[15:8], ST_OK, 8'h00, 8'h00, 1'b0);
					end
				end
				default: begin
					case (phase_q)
						PH_LENLO: begin
							n_prefix = {8'h00, item.data_byte};
							n_phase  = PH_LENHI;
						end
						PH_LENHI: begin
							n_prefix = pref_full;
							n_pos    = 16'd0;
							if (pref_full == 16'd0) begin
								n_phase = PH_IDLE;
								push_c.count = 2'd1;
								push_c.first = mk_res(OUT_STATUS, 8'h00, ST_EMPTY, 8'h00, 8'h00,
									1'b1);
							end else if (pref_full > 16'(REPLY_MAX)) begin
								n_phase = PH_DRAIN;
							end else begin
								n_crc   = CRC_INIT;
								n_rep   = 1'b0;
								n_phase = PH_BODY;
							end
						end
						PH_DRAIN: begin
							n_pos = pos_inc[15:0];
							if (pos_inc >= len17) begin
								n_phase = PH_IDLE;
								push_c.count = 2'd1;
								push_c.first = mk_res(OUT_STATUS, 8'h00, ST_TOO_LONG, 8'h00,
									8'h00, 1'b1);
							end
						end
						PH_BODY, PH_TAIL1, PH_TAIL2: begin
							if (phase_q == PH_BODY) begin
								if (idx + 17'd1 >= len17) begin
									n_phase = PH_TAIL1;
								end else begin
									n_pos = pos_inc[15:0];
								end
							end else if (phase_q == PH_TAIL1) begin
								n_phase = PH_TAIL2;
							end
							if (idx < 17'd2) begin
								if (idx == 17'd0) begin
									n_h0  = item.data_byte;
									n_sp1 = crc_out;
								end else begin
									n_h1  = item.data_byte;
									n_sp2 = crc_out;
								end
							end else if ((idx == 17'd2) && !rep_now) begin
								n_rep = 1'b0;
								if (prefix_q > 16'd2) begin
									n_crc = crc_out;
									n_h2  = item.data_byte;
								end else if (prefix_q > 16'd1) begin
									n_crc = sp2_q;
								end else begin
									n_crc = sp1_q;
								end
								if (prefix_q > 16'd1) begin
									n_reply = h1_q;
								end
								if (prefix_q >= 16'd5) begin
									push_c.count = 2'd1;
									push_c.first = mk_res(OUT_PAYLOAD, item.data_byte, ST_OK,
										8'h00, 8'h00, 1'b0);
								end
							end else begin
								if (idx == 17'd2) begin
									n_rep = 1'b1;
								end
								if (f_idx < len17) begin
									n_crc = crc_out;
									if (f_idx == 17'd0) begin
										n_h0 = item.data_byte;
									end
									if (f_idx == 17'd1) begin
										n_reply = item.data_byte;
									end
									if (f_idx == 17'd2) begin
										n_h2 = item.data_byte;
									end
								end
								if ((f_idx >= 17'd2) && (f_plus3 <= {2'b00, prefix_q})) begin
									push_c.count = 2'd1;
									push_c.first = mk_res(OUT_PAYLOAD, item.data_byte, ST_OK,
										8'h00, 8'h00, 1'b0);
								end
							end
							if (idx == len17 + 17'd1) begin
								n_phase = PH_IDLE;
								push_c.count = 2'd1;
								push_c.first = final_res(prefix_q, n_crc, n_h0, n_reply, n_h2,
									dev_addr_q, exp_q);
							end
						end
						default: begin
						end
					endcase
				end
			endcase
		end
	end

	assign push = push_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			dev_addr_q <= DEV_ADDR_RESET;
			dev_crc_q  <= crc_byte(CRC_INIT, DEV_ADDR_RESET);
			crc_q      <= CRC_INIT;
			exp_q      <= 8'h00;
			cnt_q      <= '0;
			prefix_q   <= 16'd0;
			pos_q      <= 16'd0;
			rep_q      <= 1'b0;
			reply_q    <= 8'h00;
		end else begin
			if (cfg_valid) begin
				dev_addr_q <= cfg_data;
				dev_crc_q  <= crc_byte(CRC_INIT, cfg_data);
			end
			phase_q  <= n_phase;
			crc_q    <= n_crc;
			exp_q    <= n_exp;
			cnt_q    <= n_cnt;
			prefix_q <= n_prefix;
			pos_q    <= n_pos;
			rep_q    <= n_rep;
			reply_q  <= n_reply;
		end
	end

	always_ff @(posedge clk) begin
		h0_q  <= n_h0;
		h1_q  <= n_h1;
		h2_q  <= n_h2;
		sp1_q <= n_sp1;
		sp2_q <= n_sp2;
	end

endmodule
`default_nettype wire

### design/crc16rr_result_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crc16rr_result_fifo
// Small result queue that takes up to two results a cycle and hands one
// result a transfer to the output channel.
// ---------------------------------------------------------------------------
module crc16rr_result_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  crc16rr_pkg::push_t    push,
	output logic                  room,
	output logic                  m_valid,
	input  logic                  m_ready,
	output crc16rr_pkg::result_t  head
);
	import crc16rr_pkg::*;

	result_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   rd_ptr_q, wr_ptr_q, wr_ptr_nx;
	logic [FIFO_CNT_W-1:0]   cnt_q, cnt_after_pop;
	logic                    pop;

	assign m_valid       = (cnt_q != '0);
	assign pop           = m_valid && m_ready;
	assign head          = mem_q[rd_ptr_q];
	assign wr_ptr_nx     = wr_ptr_q + FIFO_PTR_W'(1);
	assign cnt_after_pop = cnt_q - FIFO_CNT_W'(pop);
	assign room          = (cnt_after_pop <= FIFO_CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.count);
			cnt_q    <= cnt_after_pop + FIFO_CNT_W'(push.count);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.second;
		end
	end

endmodule
`default_nettype wire

### test/crc16_request_reply_framer_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// crc16_request_reply_framer_tb
// Self-checking testbench for the CRC-16 request and reply framer. A model of
// the framer inside the bench predicts every transfer on the result stream,
// and a checker compares each one field by field. Directed cases cover every
// reply status, the repeated length prefix, the payload limit, items out of
// place and several device addresses; randomized request and reply traffic
// follows, with random gaps and stalls on both streams.
// ---------------------------------------------------------------------------
module crc16_request_reply_framer_tb;

	import crc16rr_pkg::*;

	localparam int WRITE_LIMIT  = WRITE_MAX_DEFAULT;
	localparam int REPLY_LIMIT  = REPLY_MAX_DEFAULT;
	localparam int RANDOM_ITEMS = 380;
	localparam int IDLE_GUARD   = 8;
	localparam int CYCLE_LIMIT  = 2000000;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_BUILD,
		FR_LEN_LO,
		FR_LEN_HI,
		FR_BODY,
		FR_TAIL1,
		FR_TAIL2,
		FR_DRAIN
	} framer_phase_t;

	typedef enum int {
		R_GOOD,
		R_BAD_CRC,
		R_BAD_ADDR,
		R_EXCEPTION,
		R_BAD_FUNC
	} reply_flavor_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // func_code [7:0], data_byte [15:8]
	logic [1:0]  s_tuser;   // kind [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // out_byte [7:0], status [10:8],
	                        // exception_code [18:11], payload_length [26:19]
	logic [1:0]  m_tuser;   // out_kind [1:0]
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	logic [7:0]    addr_reg   = DEV_ADDR_RESET;
	logic [15:0]   crc_acc    = CRC_INIT;
	framer_phase_t ph         = FR_IDLE;
	logic [7:0]    req_func   = 8'h00;
	int unsigned   req_len    = 0;
	int unsigned   rep_len    = 0;
	int unsigned   body_pos   = 0;
	logic [7:0]    hold[3]    = '{8'h00, 8'h00, 8'h00};
	logic          dup_prefix = 1'b0;
	logic [7:0]    rep_func   = 8'h00;

	result_t     framer_outputs_due[$];
	logic [7:0]  reply_bytes[$];
	int unsigned accepted_items = 0;
	int unsigned error_count    = 0;
	bit          calm           = 1'b0;
	bit          steady_send    = 1'b0;

	crc16_request_reply_framer #(
		.WRITE_MAX(WRITE_LIMIT),
		.REPLY_MAX(REPLY_LIMIT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Bit-serial form of the reflected CRC-16 update.
	function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] c;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ data[i]) begin
				c = {1'b0, c[15:1]} ^ CRC_POLY;
			end else begin
				c = {1'b0, c[15:1]};
			end
		end
		return c;
	endfunction

	function automatic int unsigned gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic void push_result(input okind_t ok, input logic [7:0] b, input status_t st,
			input logic [7:0] ex, input logic [7:0] pl, input logic lst);
		result_t r;
		r.out_kind       = ok;
		r.out_byte       = b;
		r.status         = st;
		r.exception_code = ex;
		r.payload_length = pl;
		r.last           = lst;
		framer_outputs_due.push_back(r);
	endfunction

	function automatic void frame_take(input int unsigned f, input logic [7:0] b);
		if (f < rep_len) begin
			crc_acc = crc16_update(crc_acc, b);
			if (f == 0) hold[0] = b;
			if (f == 1) rep_func = b;
			if (f == 2) hold[2] = b;
			if (f >= 2 && f + 3 <= rep_len) begin
				push_result(OUT_PAYLOAD, b, ST_OK, 8'h00, 8'h00, 1'b0);
			end
		end
	endfunction

	function automatic void close_reply();
		status_t     st;
		logic [7:0]  ex;
		logic [7:0]  pl;
		int unsigned n;
		ex = 8'h00;
		pl = 8'h00;
		if (rep_len < 4) begin
			st = ST_FORMAT;
		end else if (crc_acc != 16'h0000) begin
			st = ST_CRC;
		end else if (hold[0] != addr_reg) begin
			st = ST_FORMAT;
		end else if (rep_func == (req_func | EXC_FLAG)) begin
			st = ST_EXCEPTION;
			ex = (rep_len >= 5) ? hold[2] : 8'h00;
		end else if (rep_func != req_func) begin
			st = ST_FORMAT;
		end else begin
			st = ST_OK;
			n  = rep_len - 4;
			pl = (n > 255) ? 8'hFF : n[7:0];
		end
		ph = FR_IDLE;
		push_result(OUT_STATUS, 8'h00, st, ex, pl, 1'b1);
	endfunction

	function automatic void body_take(input int unsigned idx, input logic [7:0] b);
		logic [7:0] h0;
		logic [7:0] h1;
		if (idx < 2) begin
			hold[idx[1:0]] = b;
		end else if (idx == 2) begin
			dup_prefix = (hold[0] == rep_len[7:0]) && (hold[1] == rep_len[15:8]) &&
				(b == addr_reg);
			if (dup_prefix) begin
				frame_take(0, b);
			end else begin
				h0 = hold[0];
				h1 = hold[1];
				frame_take(0, h0);
				frame_take(1, h1);
				frame_take(2, b);
			end
		end else begin
			frame_take(dup_prefix ? idx - 2 : idx, b);
		end
		if (idx == rep_len + 1) close_reply();
	endfunction

	// Returns 0 when the framer ignores the item.
	function automatic bit compute_framer_outputs(input kind_t k, input logic [7:0] func,
			input logic [7:0] data);
		bit          acted;
		int unsigned idx;
		acted = 1'b1;
		case (k)
			KIND_START: begin
				req_func = func;
				req_len  = 0;
				crc_acc  = crc16_update(crc16_update(CRC_INIT, addr_reg), func);
				ph       = FR_BUILD;
				push_result(OUT_TX, addr_reg, ST_OK, 8'h00, 8'h00, 1'b0);
				push_result(OUT_TX, func, ST_OK, 8'h00, 8'h00, 1'b0);
			end
			KIND_PAYLOAD: begin
				if (ph != FR_BUILD) begin
					acted = 1'b0;
				end else if (req_len >= WRITE_LIMIT) begin
					ph = FR_IDLE;
					push_result(OUT_STATUS, 8'h00, ST_PARAM, 8'h00, 8'h00, 1'b1);
				end else begin
					req_len++;
					crc_acc = crc16_update(crc_acc, data);
					push_result(OUT_TX, data, ST_OK, 8'h00, 8'h00, 1'b0);
				end
			end
			KIND_END: begin
				if (ph != FR_BUILD) begin
					acted = 1'b0;
				end else begin
					ph = FR_LEN_LO;
					push_result(OUT_TX, crc_acc[7:0], ST_OK, 8'h00, 8'h00, 1'b0);
					push_result(OUT_TX, crc_acc[15:8], ST_OK, 8'h00, 8'h00, 1'b0);
				end
			end
			default: begin
				case (ph)
					FR_LEN_LO: begin
						rep_len = {24'd0, data};
						ph      = FR_LEN_HI;
					end
					FR_LEN_HI: begin
						rep_len[15:8] = data;
						body_pos      = 0;
						if (rep_len == 0) begin
							ph = FR_IDLE;
							push_result(OUT_STATUS, 8'h00, ST_EMPTY, 8'h00, 8'h00, 1'b1);
						end else if (rep_len > REPLY_LIMIT) begin
							ph = FR_DRAIN;
						end else begin
							crc_acc    = CRC_INIT;
							dup_prefix = 1'b0;
							ph         = FR_BODY;
						end
					end
					FR_DRAIN: begin
						body_pos++;
						if (body_pos >= rep_len) begin
							ph = FR_IDLE;
							push_result(OUT_STATUS, 8'h00, ST_TOO_LONG, 8'h00, 8'h00, 1'b1);
						end
					end
					FR_BODY: begin
						idx = body_pos;
						if (idx + 1 >= rep_len) begin
							ph = FR_TAIL1;
						end else begin
							body_pos++;
						end
						body_take(idx, data);
					end
					FR_TAIL1: begin
						ph = FR_TAIL2;
						body_take(rep_len, data);
					end
					FR_TAIL2: begin
						body_take(rep_len + 1, data);
					end
					default: begin
						acted = 1'b0;
					end
				endcase
			end
		endcase
		return acted;
	endfunction

	task automatic send_item(input kind_t k, input logic [7:0] func, input logic [7:0] data);
		int unsigned gap;
		gap = (steady_send || calm || $urandom_range(0, 99) >= 25) ? 0 : gap_len();
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 16'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {data, func};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (compute_framer_outputs(k, func, data)) accepted_items++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tdata  <= 16'($urandom);
		while (framer_outputs_due.size() != 0) @(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	task automatic write_address(input logic [7:0] a);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= a;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		addr_reg = a;
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data  <= 8'($urandom);
	endtask

	task automatic run_request(input logic [7:0] func, input int unsigned n);
		send_item(KIND_START, func, 8'($urandom));
		repeat (n) send_item(KIND_PAYLOAD, 8'($urandom), 8'($urandom));
		send_item(KIND_END, 8'($urandom), 8'($urandom));
	endtask

	// Fills reply_bytes: prefix, len + 2 bytes (len if too long, none for 0).
	task automatic queue_reply(input int unsigned len, input bit dup, input reply_flavor_t flavor);
		logic [7:0]  frame[$];
		logic [15:0] c;
		int unsigned pos;
		reply_bytes.delete();
		reply_bytes.push_back(len[7:0]);
		reply_bytes.push_back(len[15:8]);
		if (len > REPLY_LIMIT) begin
			repeat (len) reply_bytes.push_back(8'($urandom));
		end else if (len != 0) begin
			if (len < 4) begin
				repeat (len) frame.push_back(8'($urandom));
			end else begin
				frame.push_back((flavor == R_BAD_ADDR) ?
					(addr_reg ^ 8'($urandom_range(1, 255))) : addr_reg);
				case (flavor)
					R_EXCEPTION: frame.push_back(req_func | EXC_FLAG);
					R_BAD_FUNC:  frame.push_back(req_func ^ 8'($urandom_range(1, 255)));
					default:     frame.push_back(req_func);
				endcase
				repeat (len - 4) frame.push_back(8'($urandom));
				c = CRC_INIT;
				foreach (frame[i]) c = crc16_update(c, frame[i]);
				frame.push_back(c[7:0]);
				frame.push_back(c[15:8]);
				if (flavor == R_BAD_CRC) begin
					pos        = $urandom_range(0, len - 1);
					frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
				end
			end
			if (dup) begin
				reply_bytes.push_back(len[7:0]);
				reply_bytes.push_back(len[15:8]);
			end
			foreach (frame[i]) reply_bytes.push_back(frame[i]);
			if (!dup) repeat (2) reply_bytes.push_back(8'($urandom));
		end
	endtask

	task automatic send_reply_bytes(input int unsigned count);
		for (int unsigned i = 0; i < count && i < reply_bytes.size(); i++) begin
			send_item(KIND_REPLY, 8'($urandom), reply_bytes[i]);
		end
	endtask

	task automatic exchange(input logic [7:0] func, input int unsigned n, input int unsigned len,
			input bit dup, input reply_flavor_t flavor);
		run_request(func, n);
		queue_reply(len, dup, flavor);
		send_reply_bytes(reply_bytes.size());
	endtask

	task automatic test_request_frames();
		exchange(8'h00, 0, 4, 1'b0, R_GOOD);
		send_item(KIND_START, 8'hFF, 8'h00);
		send_item(KIND_PAYLOAD, 8'h00, 8'h00);
		send_item(KIND_PAYLOAD, 8'hFF, 8'hFF);
		send_item(KIND_END, 8'hFF, 8'hFF);
		queue_reply(6, 1'b0, R_GOOD);
		send_reply_bytes(reply_bytes.size());
	endtask

	task automatic test_reply_status();
		exchange(8'h03, 1, 6, 1'b0, R_GOOD);
		exchange(8'h03, 1, 6, 1'b0, R_BAD_CRC);
		exchange(8'h03, 1, 6, 1'b0, R_BAD_ADDR);
		exchange(8'h03, 1, 5, 1'b0, R_EXCEPTION);
		exchange(8'h03, 0, 4, 1'b0, R_EXCEPTION);
		exchange(8'h03, 0, 6, 1'b0, R_BAD_FUNC);
		for (int n = 1; n < 4; n++) exchange(8'h04, 0, n, 1'b0, R_GOOD);
		exchange(8'h04, 0, 0, 1'b0, R_GOOD);
		exchange(8'h04, 0, REPLY_LIMIT, 1'b0, R_GOOD);
		exchange(8'h04, 0, REPLY_LIMIT + 1, 1'b0, R_GOOD);
	endtask

	task automatic test_prefix_repeat();
		exchange(8'h06, 2, 5, 1'b1, R_GOOD);
		exchange(8'h06, 2, 8, 1'b1, R_BAD_ADDR);
		exchange(8'h06, 0, 3, 1'b1, R_GOOD);
	endtask

	task automatic test_payload_limit();
		exchange(8'h10, WRITE_LIMIT, 6, 1'b0, R_GOOD);
		run_request(8'h10, WRITE_LIMIT + 1);
		send_item(KIND_REPLY, 8'h00, 8'h06);
	endtask

	task automatic test_out_of_place_items();
		send_item(KIND_PAYLOAD, 8'h00, 8'h55);
		send_item(KIND_END, 8'h00, 8'hAA);
		send_item(KIND_REPLY, 8'h00, 8'h06);
		send_item(KIND_START, 8'h05, 8'h00);
		send_item(KIND_REPLY, 8'h00, 8'h06);
		send_item(KIND_START, 8'h06, 8'h00);
		send_item(KIND_END, 8'h00, 8'h00);
		queue_reply(8, 1'b0, R_GOOD);
		send_reply_bytes(5);
		exchange(8'h07, 1, 6, 1'b0, R_GOOD);
	endtask

	task automatic test_device_address();
		logic [7:0] addrs[3];
		addrs[0] = 8'h00;
		addrs[1] = 8'hFF;
		addrs[2] = 8'($urandom);
		foreach (addrs[i]) begin
			write_address(addrs[i]);
			exchange(8'h03, 2, 7, 1'b0, R_GOOD);
			exchange(8'h03, 0, 6, 1'b1, R_GOOD);
		end
	endtask

	task automatic test_long_drain();
		steady_send = 1'b1;
		exchange(8'h03, 0, 16'h0121, 1'b0, R_GOOD);
		steady_send = 1'b0;
	endtask

	task automatic test_random_traffic();
		int unsigned   target;
		int unsigned   sel;
		int unsigned   pick;
		int unsigned   n;
		int unsigned   len;
		int unsigned   txn;
		logic [7:0]    func;
		reply_flavor_t flavor;
		target = accepted_items + RANDOM_ITEMS;
		txn    = 0;
		while (accepted_items < target) begin
			sel  = $urandom_range(0, 99);
			func = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 16));
			pick = $urandom_range(0, 99);
			n    = (pick < 90) ? $urandom_range(0, 8) :
				(pick < 97) ? $urandom_range(9, WRITE_LIMIT) :
				$urandom_range(WRITE_LIMIT + 1, WRITE_LIMIT + 3);
			pick = $urandom_range(0, 99);
			len  = (pick < 5)  ? 0 :
				(pick < 10) ? $urandom_range(1, 3) :
				(pick < 15) ? $urandom_range(REPLY_LIMIT + 1, REPLY_LIMIT + 8) :
				(pick < 18) ? $urandom_range(100, REPLY_LIMIT) :
				$urandom_range(4, 16);
			pick   = $urandom_range(0, 9);
			flavor = (pick < 5) ? R_GOOD : (pick == 5) ? R_BAD_CRC :
				(pick == 6) ? R_BAD_ADDR : (pick < 9) ? R_EXCEPTION : R_BAD_FUNC;
			if (sel < 80) begin
				exchange(func, n, len, $urandom_range(0, 2) == 0, flavor);
				txn++;
				if (ph == FR_IDLE && txn % 8 == 0) begin
					pick = $urandom_range(0, 3);
					write_address((pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom));
				end
			end else if (sel < 90) begin
				repeat ($urandom_range(1, 6)) begin
					send_item(kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
				end
			end else begin
				run_request(func, n);
				queue_reply(len, $urandom_range(0, 2) == 0, flavor);
				send_reply_bytes($urandom_range(0, reply_bytes.size() - 1));
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (framer_outputs_due.size() == 0) begin
				$error("unexpected result: out_kind %0d out_byte %0d status %0d",
					m_tuser, m_tdata[7:0], m_tdata[10:8]);
				error_count++;
			end else begin
				want = framer_outputs_due.pop_front();
				check_field("out_kind", 8'(want.out_kind), 8'(m_tuser));
				check_field("out_byte", want.out_byte, m_tdata[7:0]);
				check_field("status", 8'(want.status), 8'(m_tdata[10:8]));
				check_field("exception_code", want.exception_code, m_tdata[18:11]);
				check_field("payload_length", want.payload_length, m_tdata[26:19]);
				check_field("last", 8'(want.last), 8'(m_tlast));
			end
		end
	end

	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		stall    = 0;
		forever begin
			@(negedge clk);
			if (stall != 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 20) begin
				stall = gap_len() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Alternating stretches with and without idling on both streams.
	initial begin
		forever begin
			calm = 1'b0;
			repeat ($urandom_range(200, 600)) @(posedge clk);
			calm = 1'b1;
			repeat ($urandom_range(50, 200)) @(posedge clk);
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = KIND_START;
		s_tdata   = 16'h0000;
		cfg_valid = 1'b0;
		cfg_data  = 8'h00;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_request_frames();
		wait_idle();
		test_reply_status();
		wait_idle();
		test_prefix_repeat();
		wait_idle();
		test_payload_limit();
		wait_idle();
		test_out_of_place_items();
		wait_idle();
		test_device_address();
		wait_idle();
		test_long_drain();
		wait_idle();
		test_random_traffic();
		wait_idle();
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
